### hdl/ics_pkg.sv
// shared constants and types for the streaming infix calculator
`timescale 1ns / 1ps

package ics_pkg;

  localparam int VALUE_WIDTH = 32;
  localparam int CNT_W = $clog2(VALUE_WIDTH);

  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_TIMES  = 8'h2A;
  localparam logic [7:0] CH_DIVIDE = 8'h2F;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  localparam logic [1:0] OP_PLUS   = 2'd0;
  localparam logic [1:0] OP_MINUS  = 2'd1;
  localparam logic [1:0] OP_TIMES  = 2'd2;
  localparam logic [1:0] OP_DIVIDE = 2'd3;

  typedef logic [VALUE_WIDTH-1:0] value_t;

  typedef struct packed {
    logic load;
    logic digit;
    logic add_term;
    logic start_mul;
    logic start_div;
    logic div_zero;
    logic write_term;
    logic finish;
    logic emit;
  } ics_cmd_t;

  typedef struct packed {
    logic       is_digit;
    logic       is_op;
    logic       last;
    logic [1:0] pend_op;
    logic       accum_zero;
    logic       unit_done;
    logic       out_full;
  } ics_stat_t;

endpackage

### hdl/ics_arith.sv
// shared iterative unit: shift-add multiply and restoring signed divide
`timescale 1ns / 1ps

module ics_arith (
  input  logic            clk,
  input  logic            rst,
  input  logic            start_mul,
  input  logic            start_div,
  input  ics_pkg::value_t a,
  input  ics_pkg::value_t b,
  output logic            done,
  output ics_pkg::value_t result
);
  import ics_pkg::*;

  logic             busy;
  logic [CNT_W-1:0] cnt;
  logic             is_div;
  logic             neg;
  value_t           acc;
  value_t           shf;
  value_t           opd;

  value_t                 mag_a;
  value_t                 mag_b;
  logic [VALUE_WIDTH:0]   rem_shift;
  logic [VALUE_WIDTH:0]   rem_diff;
  logic                   fits;

  assign mag_a = a[VALUE_WIDTH-1] ? (~a + 1'b1) : a;
  assign mag_b = b[VALUE_WIDTH-1] ? (~b + 1'b1) : b;

  // restoring step: bring down next dividend bit, subtract if it fits
  assign rem_shift = {acc, shf[VALUE_WIDTH-1]};
  assign rem_diff  = rem_shift - {1'b0, opd};
  assign fits      = !rem_diff[VALUE_WIDTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start_mul || start_div) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(VALUE_WIDTH - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_mul) begin
      is_div <= 1'b0;
      neg    <= 1'b0;
      acc    <= '0;
      shf    <= b;
      opd    <= a;
    end else if (start_div) begin
      is_div <= 1'b1;
      neg    <= a[VALUE_WIDTH-1] ^ b[VALUE_WIDTH-1];
      acc    <= '0;
      shf    <= mag_a;
      opd    <= mag_b;
    end else if (busy) begin
      if (is_div) begin
        acc <= fits ? rem_diff[VALUE_WIDTH-1:0] : rem_shift[VALUE_WIDTH-1:0];
        shf <= {shf[VALUE_WIDTH-2:0], fits};
      end else begin
        if (shf[0]) begin
          acc <= acc + opd;
        end
        shf <= shf >> 1;
        opd <= opd << 1;
      end
    end
  end

  always_comb begin
    if (is_div) begin
      result = neg ? (~shf + 1'b1) : shf;
    end else begin
      result = acc;
    end
  end

endmodule

### hdl/ics_ctrl.sv
// sequencing state machine for the calculator
`timescale 1ns / 1ps

module ics_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  ics_pkg::ics_stat_t stat,
  output ics_pkg::ics_cmd_t  cmd
);
  import ics_pkg::*;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DECODE = 3'd1;
  localparam logic [2:0] S_APPLY  = 3'd2;
  localparam logic [2:0] S_WAIT   = 3'd3;
  localparam logic [2:0] S_FINISH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;

  assign in_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.digit  = stat.is_digit;
        state_next = (stat.is_op || stat.last) ? S_APPLY : S_IDLE;
      end
      S_APPLY: begin
        unique case (stat.pend_op)
          OP_PLUS, OP_MINUS: begin
            cmd.add_term = 1'b1;
            state_next   = S_FINISH;
          end
          OP_TIMES: begin
            cmd.start_mul = 1'b1;
            state_next    = S_WAIT;
          end
          OP_DIVIDE: begin
            if (stat.accum_zero) begin
              cmd.div_zero = 1'b1;
              state_next   = S_FINISH;
            end else begin
              cmd.start_div = 1'b1;
              state_next    = S_WAIT;
            end
          end
          default: begin
            state_next = S_FINISH;
          end
        endcase
      end
      S_WAIT: begin
        if (stat.unit_done) begin
          cmd.write_term = 1'b1;
          state_next     = S_FINISH;
        end
      end
      S_FINISH: begin
        // for a final character, hold while the previous result is still waiting downstream
        if (!(stat.last && stat.out_full)) begin
          cmd.finish = 1'b1;
          cmd.emit   = stat.last;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### hdl/ics_dp.sv
// calculator datapath: character decode, term registers, output register
`timescale 1ns / 1ps

module ics_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         char_code,
  input  logic               last_char,
  input  ics_pkg::ics_cmd_t  cmd,
  output ics_pkg::ics_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] total,
  output logic               div_error
);
  import ics_pkg::*;

  logic [7:0] char_reg;
  logic       last_reg;
  value_t     running_sum;
  value_t     pending_term;
  value_t     number_accum;
  logic [1:0] pending_op;
  logic       error_seen;

  logic       is_digit;
  logic       is_op;
  logic [1:0] op_code;
  value_t     digit_val;
  value_t     accum_next;
  value_t     sum_out;
  logic       unit_done;
  value_t     unit_result;

  assign is_digit  = (char_reg >= CH_ZERO) && (char_reg <= CH_NINE);
  assign digit_val = VALUE_WIDTH'(char_reg - CH_ZERO);
  // times ten as two shifts and an add
  assign accum_next = (number_accum << 3) + (number_accum << 1) + digit_val;
  assign sum_out    = running_sum + pending_term;

  always_comb begin
    is_op   = 1'b1;
    op_code = OP_PLUS;
    unique case (char_reg)
      CH_PLUS:   op_code = OP_PLUS;
      CH_MINUS:  op_code = OP_MINUS;
      CH_TIMES:  op_code = OP_TIMES;
      CH_DIVIDE: op_code = OP_DIVIDE;
      default:   is_op   = 1'b0;
    endcase
  end

  ics_arith u_arith (
    .clk       (clk),
    .rst       (rst),
    .start_mul (cmd.start_mul),
    .start_div (cmd.start_div),
    .a         (pending_term),
    .b         (number_accum),
    .done      (unit_done),
    .result    (unit_result)
  );

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      char_reg <= char_code;
      last_reg <= last_char;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum  <= '0;
      pending_term <= '0;
      number_accum <= '0;
      pending_op   <= OP_PLUS;
      error_seen   <= 1'b0;
    end else begin
      if (cmd.digit) begin
        number_accum <= accum_next;
      end
      if (cmd.add_term) begin
        running_sum  <= sum_out;
        pending_term <= (pending_op == OP_MINUS) ? (~number_accum + 1'b1) : number_accum;
      end
      if (cmd.div_zero) begin
        pending_term <= '0;
        error_seen   <= 1'b1;
      end
      if (cmd.write_term) begin
        pending_term <= unit_result;
      end
      if (cmd.finish) begin
        number_accum <= '0;
        if (is_op) begin
          pending_op <= op_code;
        end
      end
      // end of expression: back to the starting state
      if (cmd.emit) begin
        running_sum  <= '0;
        pending_term <= '0;
        number_accum <= '0;
        pending_op   <= OP_PLUS;
        error_seen   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      total     <= 32'(sum_out);
      div_error <= error_seen;
    end
  end

  always_comb begin
    stat            = '0;
    stat.is_digit   = is_digit;
    stat.is_op      = is_op;
    stat.last       = last_reg;
    stat.pend_op    = pending_op;
    stat.accum_zero = (number_accum == '0);
    stat.unit_done  = unit_done;
    stat.out_full   = out_valid && out_stall;
  end

endmodule

### hdl/infix_calculator_stream_top.sv
// top level of the streaming infix calculator
`timescale 1ns / 1ps

// Evaluates an expression of unsigned decimal numbers, spaces and + - * /
// fed one character per transaction; last_char marks the final character,
// and that transaction yields one result (total, div_error). A digit only
// extends the number being read, and an ignored character changes nothing.
// An operator, or the final character, applies the pending operator:
// + and - or a division by zero update the terms directly; * and / use the
// shared shift-add / restoring-divide unit that retires one bit per cycle.
// One result register sits at the output, so characters of the next
// expression are taken while a total waits; only a second final character
// waits for that register to drain. Division by zero gives a zero term and
// sets div_error; values wrap at VALUE_WIDTH bits and / truncates toward zero.
module infix_calculator_stream_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         char_code,
  input  logic               last_char,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] total,
  output logic               div_error
);
  import ics_pkg::*;

  ics_cmd_t  cmd;
  ics_stat_t stat;

  ics_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ics_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .char_code (char_code),
    .last_char (last_char),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .total     (total),
    .div_error (div_error)
  );

  // a new total never overwrites one that is still held
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !(out_valid && out_stall))
    else $error("result emitted while output register held");

  // the controller leaves idle right after taking a character
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // only one update of the open term per cycle
  a_one_term_update: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.add_term, cmd.start_mul, cmd.start_div, cmd.div_zero, cmd.write_term}))
    else $error("conflicting term commands");

  // emitting always closes the operator step
  a_emit_finishes: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> cmd.finish)
    else $error("emit without finish");

endmodule

### tb/infix_calculator_stream_top_tb.sv
// testbench for the streaming infix calculator: character stimulus, shadow evaluator, scoreboard
`timescale 1ns / 1ps

module infix_calculator_stream_top_tb;
  import ics_pkg::*;

  localparam int ITEM_TARGET  = 550;
  localparam int HOLD_AT      = 12;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 2 * (VALUE_WIDTH + 6);
  localparam int DECIMAL_BASE = 10;

  typedef struct packed {
    logic signed [31:0] total;
    logic               div_error;
  } calc_result_t;

  // shadow evaluator: running sum plus one open term, and the queue of totals it predicts
  class calc_scoreboard;
    value_t       run_sum;
    value_t       open_term;
    value_t       num_acc;
    logic [1:0]   pend_op;
    logic         div_seen;
    calc_result_t totals_q[$];
    int           errors;
    int           checked;
    int           div_results;

    function new();
      restart();
    endfunction

    function void restart();
      run_sum   = '0;
      open_term = '0;
      num_acc   = '0;
      pend_op   = OP_PLUS;
      div_seen  = 1'b0;
    endfunction

    function int pending();
      return totals_q.size();
    endfunction

    function void note_char(logic [7:0] c, logic last);
      logic         is_op;
      logic [1:0]   op;
      value_t       ma, mb, q;
      calc_result_t r;
      is_op = 1'b1;
      op    = OP_PLUS;
      unique case (c)
        CH_PLUS:   op = OP_PLUS;
        CH_MINUS:  op = OP_MINUS;
        CH_TIMES:  op = OP_TIMES;
        CH_DIVIDE: op = OP_DIVIDE;
        default:   is_op = 1'b0;
      endcase
      if (c >= CH_ZERO && c <= CH_NINE)
        num_acc = num_acc * value_t'(DECIMAL_BASE) + value_t'(c - CH_ZERO);
      if (is_op || last) begin
        unique case (pend_op)
          OP_PLUS: begin
            run_sum   = run_sum + open_term;
            open_term = num_acc;
          end
          OP_MINUS: begin
            run_sum   = run_sum + open_term;
            open_term = -num_acc;
          end
          OP_TIMES: open_term = open_term * num_acc;
          default: begin
            if (num_acc == '0) begin
              open_term = '0;
              div_seen  = 1'b1;
            end else begin
              // divide magnitudes, then restore the sign: truncates toward zero
              ma = open_term[VALUE_WIDTH-1] ? -open_term : open_term;
              mb = num_acc[VALUE_WIDTH-1] ? -num_acc : num_acc;
              q  = ma / mb;
              open_term = (open_term[VALUE_WIDTH-1] ^ num_acc[VALUE_WIDTH-1]) ? -q : q;
            end
          end
        endcase
        num_acc = '0;
        if (is_op)
          pend_op = op;
      end
      if (last) begin
        r.total     = 32'(run_sum + open_term);
        r.div_error = div_seen;
        totals_q.push_back(r);
        restart();
      end
    endfunction

    function void check_result(logic signed [31:0] t, logic e);
      calc_result_t want;
      if (totals_q.size() == 0) begin
        $error("total %0d (div_error %0b) with no expression outstanding", t, e);
        errors++;
        return;
      end
      want = totals_q.pop_front();
      checked++;
      if (want.div_error)
        div_results++;
      if (t !== want.total) begin
        $error("total: expected %0d, actual %0d", want.total, t);
        errors++;
      end
      if (e !== want.div_error) begin
        $error("div_error: expected %0b, actual %0b", want.div_error, e);
        errors++;
      end
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [7:0]         char_code = '0;
  logic               last_char = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] total;
  logic               div_error;

  calc_scoreboard sb = new();

  logic [7:0] expr_q[$];
  logic [7:0] op_chars[4] = '{CH_PLUS, CH_MINUS, CH_TIMES, CH_DIVIDE};
  string      extreme_texts[8] = '{
    "4294967295", "0-2147483648", "2147483648/4294967295",
    "0-2147483648/4294967295", "99999999999", "65536*65536",
    "5/0*3+2", "4294967295*4294967295 - 1"
  };

  bit steady   = 1'b0;
  bit hold_req = 1'b0;
  int chars_sent, ignored_chars, stall_cycles;

  infix_calculator_stream_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .char_code (char_code),
    .last_char (last_char),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .total     (total),
    .div_error (div_error)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  initial begin
    #10_000_000;
    $display("Regression FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result(total, div_error);
  end

  // result side: random stalls, one long hold counted here when requested
  initial begin : receiver
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_stall <= !steady && ($urandom_range(99) < 33);
    end
  end

  // entered and left at a falling edge; valid stays high between back-to-back transactions
  task automatic send_char(input logic [7:0] c, input logic last);
    while (!steady && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    char_code <= c;
    last_char <= last;
    @(posedge clk);
    while (in_stall) begin
      stall_cycles++;
      @(posedge clk);
    end
    sb.note_char(c, last);
    chars_sent++;
    if (!((c >= CH_ZERO && c <= CH_NINE) || c == CH_PLUS || c == CH_MINUS ||
          c == CH_TIMES || c == CH_DIVIDE || last))
      ignored_chars++;
    @(negedge clk);
  endtask

  task automatic send_expression();
    foreach (expr_q[i])
      send_char(expr_q[i], i == expr_q.size() - 1);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++)
      expr_q.push_back(s[i]);
  endtask

  task automatic build_random(input bit short_form);
    int kind, terms, len, r;
    expr_q.delete();
    kind = $urandom_range(99);
    if (short_form) begin
      expr_q.push_back(CH_ZERO + 8'($urandom_range(9)));
      expr_q.push_back(op_chars[$urandom_range(3)]);
      expr_q.push_back(CH_ZERO + 8'($urandom_range(9)));
    end else if (kind < 68) begin
      terms = $urandom_range(1, 5);
      for (int i = 0; i < terms; i++) begin
        if (i > 0)
          expr_q.push_back(op_chars[$urandom_range(3)]);
        if ($urandom_range(9) == 0)
          expr_q.push_back(" ");
        r   = $urandom_range(99);
        len = (r < 80) ? $urandom_range(1, 2) : (r < 95) ? $urandom_range(3, 6) :
              $urandom_range(10, 12);
        for (int j = 0; j < len; j++)
          expr_q.push_back(CH_ZERO + 8'($urandom_range(9)));
      end
      if ($urandom_range(4) == 0)
        expr_q.push_back(" ");
    end else if (kind < 78) begin
      push_text(extreme_texts[$urandom_range(7)]);
    end else if (kind < 90) begin
      // malformed: doubled or trailing operators, stray spaces
      len = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) begin
        r = $urandom_range(99);
        if (r < 50)
          expr_q.push_back(CH_ZERO + 8'($urandom_range(9)));
        else if (r < 80)
          expr_q.push_back(op_chars[$urandom_range(3)]);
        else
          expr_q.push_back(" ");
      end
    end else begin
      len = $urandom_range(1, 6);
      for (int i = 0; i < len; i++)
        expr_q.push_back(8'($urandom_range(255)));
    end
  endtask

  initial begin : stimulus
    int n_expr;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // blank expression, lone operator, divide by zero, precedence, ignored codes, trailing operator
    expr_q.delete(); push_text(" ");       send_expression();
    expr_q.delete(); push_text("+");       send_expression();
    expr_q.delete(); push_text("9/0");     send_expression();
    expr_q.delete(); push_text("8-6/4*3"); send_expression();
    expr_q.delete(); push_text("1");
    expr_q.push_back(8'h00);
    push_text("a");
    expr_q.push_back(8'hFF);
    send_expression();
    expr_q.delete(); push_text("12*");     send_expression();

    n_expr = 0;
    while (chars_sent < ITEM_TARGET) begin
      if (n_expr == HOLD_AT)
        hold_req = 1'b1;
      steady = (n_expr >= 30 && n_expr < 45);
      if (n_expr == 48) begin
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
      end
      build_random(n_expr >= HOLD_AT && n_expr < HOLD_AT + 8);
      send_expression();
      n_expr++;
    end
    in_valid <= 1'b0;
    steady = 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d characters (%0d ignored codes) over %0d random expressions plus directed",
             chars_sent, ignored_chars, n_expr);
    $display("checked %0d totals, %0d flagged div_error; input held off %0d cycles",
             sb.checked, sb.div_results, stall_cycles);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

### sim.f
hdl/ics_pkg.sv
hdl/ics_arith.sv
hdl/ics_ctrl.sv
hdl/ics_dp.sv
hdl/infix_calculator_stream_top.sv
tb/infix_calculator_stream_top_tb.sv
